FILE: sv/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg - shared definitions for the radix digit converter
// Widths, radix limits, queue depth, item control fields and back-end states.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // default width of the value field
  localparam int VALUE_WIDTH_DEF = 31;

  // radix register and digit widths
  localparam int RADIX_W = 4;
  localparam int DIGIT_W = 4;

  // legal radix range
  localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd9;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS = 8;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // control part of a queued item
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               is_zero;
  } item_ctl_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_SHOW
  } back_state_t;

endpackage

FILE: sv/rdc_front.sv
// ----------------------------------------------------------------------------
// rdc_front - input side of the radix digit converter
// Holds the saturating radix register, classifies each value and pushes it
// with its radix into the item queue.
// ----------------------------------------------------------------------------
module rdc_front import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [RADIX_W-1:0]     cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [VALUE_WIDTH-1:0] q_push_value,
  output item_ctl_t              q_push_ctl
);

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_nxt;

  // clamp written radix into the legal range
  always_comb begin
    radix_nxt = radix_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (cfg_wr_data > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_MIN;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // transfer into the queue whenever it has room
  assign in_ready           = !q_full;
  assign q_push             = in_valid && !q_full;
  assign q_push_value       = in_value;
  assign q_push_ctl.radix   = radix_r;
  assign q_push_ctl.is_zero = (in_value == '0);

endmodule

FILE: sv/rdc_queue.sv
// ----------------------------------------------------------------------------
// rdc_queue - short item queue between front and back
// Register-based FIFO that lets the input side and the converter stall
// independently.
// ----------------------------------------------------------------------------
module rdc_queue import rdc_pkg::*; #(
  parameter int DATA_W = VALUE_WIDTH_DEF + RADIX_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == DEPTH_C);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/rdc_back.sv
// ----------------------------------------------------------------------------
// rdc_back - converter core of the radix digit converter
// Divides the value repeatedly by the radix (several quotient bits a cycle),
// stacks the remainders in a digit memory, then pops them out most
// significant first through a registered output stage.
// ----------------------------------------------------------------------------
module rdc_back import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_not_empty,
  input  logic [VALUE_WIDTH-1:0] q_value,
  input  item_ctl_t              q_ctl,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DIGIT_W-1:0]     out_digit,
  output logic                   out_last_digit
);

  localparam int STEPS  = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PW     = STEPS * DIV_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int IDX_W  = $clog2(VALUE_WIDTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  back_state_t          state_r, state_nxt;
  logic [PW-1:0]        q_r, q_nxt;
  logic [RADIX_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0]   rdx_r, rdx_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0]   rd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0]   out_digit_r, out_digit_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [DIGIT_W-1:0]   mem [VALUE_WIDTH];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [DIGIT_W-1:0]   mem_wd;

  logic [PW-1:0]        div_q;
  logic [RADIX_W-1:0]   div_rem;
  logic                 out_free;
  logic                 digit_done;

  // one divider cycle: DIV_BITS restoring steps on a narrow remainder
  always_comb begin
    logic [RADIX_W:0]   part;
    logic [RADIX_W-1:0] rcur;
    logic [PW-1:0]      qs;
    rcur = rem_r;
    qs   = q_r;
    part = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      part = {rcur, qs[PW-1]};
      qs   = {qs[PW-2:0], 1'b0};
      if (part >= {1'b0, rdx_r}) begin
        part  = part - {1'b0, rdx_r};
        qs[0] = 1'b1;
      end
      rcur = part[RADIX_W-1:0];
    end
    div_q   = qs;
    div_rem = rcur;
  end

  assign digit_done = (step_r == STEP_LAST);
  assign out_free   = !out_valid_r || out_ready;
  assign q_pop      = (state_r == BK_IDLE) && q_not_empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = q_ctl.is_zero ? BK_READ : BK_DIV;
        end
      end
      BK_DIV: begin
        if (digit_done && (div_q == '0)) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_free && (cnt_r == '0)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // datapath and output controls
  always_comb begin
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    rdx_nxt       = rdx_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    mem_we        = 1'b0;
    mem_wa        = cnt_r;
    mem_wd        = div_rem;
    out_valid_nxt = out_valid_r && !out_ready;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          q_nxt    = PW'(q_value);
          rem_nxt  = '0;
          rdx_nxt  = q_ctl.radix;
          step_nxt = '0;
          cnt_nxt  = '0;
          // zero value: single digit 0 straight into the stack
          if (q_ctl.is_zero) begin
            mem_we = 1'b1;
            mem_wa = '0;
            mem_wd = '0;
          end
        end
      end
      BK_DIV: begin
        q_nxt = div_q;
        if (digit_done) begin
          mem_we   = 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
          if (div_q != '0) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          rem_nxt  = div_rem;
          step_nxt = step_r + 1'b1;
        end
      end
      BK_READ: begin
        cnt_nxt = cnt_r;
      end
      BK_SHOW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = rd_data_r;
          out_last_nxt  = (cnt_r == '0);
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    rdx_r       <= rdx_nxt;
    step_r      <= step_nxt;
    cnt_r       <= cnt_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  // digit stack: one write port, registered read at the next pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[cnt_nxt];
  end

  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;

endmodule

FILE: sv/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_converter - integer to radix 2..9 digit conversion
// Accepts one unsigned value per transfer and returns its digits in the
// configured radix, most significant first, the final digit flagged.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready, one value per transfer
//   result channel: out_valid / out_ready, one digit per transfer, with
//   out_last_digit high on the least significant digit; zero gives one digit 0
//   cfg_wr_en / cfg_wr_data write the radix; values below 2 or above 9 clamp,
//   write only while the block is idle
// timing
//   a two-entry queue takes values while the converter is busy
//   the divider resolves DIV_BITS quotient bits a cycle and works through the
//   whole quotient once for each digit
//   an item passes through division, one stack read, then one digit a cycle
//   while out_ready is high; the first digit comes out only after the whole
//   division and the stack read
// reset and stall
//   reset (rst_n low, synchronous) empties the queue, drops any conversion in
//   flight and sets the radix to 2; no memory clearing pass is needed
//   when out_ready is low the current digit holds and the converter waits
// ----------------------------------------------------------------------------
module radix_digit_converter import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [RADIX_W-1:0]     cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DIGIT_W-1:0]     out_digit,
  output logic                   out_last_digit
);

  localparam int CTL_W  = $bits(item_ctl_t);
  localparam int DATA_W = VALUE_WIDTH + CTL_W;

  logic                   q_full;
  logic                   q_push;
  logic [VALUE_WIDTH-1:0] q_push_value;
  item_ctl_t              q_push_ctl;
  logic                   q_pop;
  logic                   q_not_empty;
  logic [DATA_W-1:0]      q_pop_data;
  item_ctl_t              q_pop_ctl;

  // input side and radix register
  rdc_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_value (q_push_value),
    .q_push_ctl   (q_push_ctl)
  );

  // item queue
  rdc_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({q_push_value, q_push_ctl}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  assign q_pop_ctl = item_ctl_t'(q_pop_data[CTL_W-1:0]);

  // converter core
  rdc_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_value        (q_pop_data[DATA_W-1:CTL_W]),
    .q_ctl          (q_pop_ctl),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit)
  );

endmodule

FILE: bench/radix_digit_converter_check.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_check - digit stream checker
// Watches the radix register writes and both channels of the converter,
// predicts the digit sequence of every value taken and compares each digit
// transfer against the oldest predicted digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter_check import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [RADIX_W-1:0]     cfg_wr_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [DIGIT_W-1:0]     out_digit,
  input  logic                   out_last_digit,
  output int                     pending_digits,
  output int                     mismatch_count
);

  // one predicted digit transfer
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
  } digit_xfer_t;

  digit_xfer_t        expected_digits[$];
  digit_xfer_t        oldest;
  logic [RADIX_W-1:0] radix_q = RADIX_MIN;

  // out-of-range register writes clamp to the nearest legal radix
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] wr);
    if (wr < RADIX_MIN) return RADIX_MIN;
    if (wr > RADIX_MAX) return RADIX_MAX;
    return wr;
  endfunction

  // divide down to collect digits low first, then queue them high first
  task automatic queue_digits(input logic [VALUE_WIDTH-1:0] value,
                              input logic [RADIX_W-1:0] radix);
    logic [63:0]  rest;
    digit_xfer_t  low_first[$];
    digit_xfer_t  d;
    rest = 64'(value);
    do begin
      d.digit      = DIGIT_W'(rest % 64'(radix));
      d.last_digit = (low_first.size() == 0);
      low_first.push_back(d);
      rest = rest / 64'(radix);
    end while (rest != 0);
    while (low_first.size() > 0) expected_digits.push_back(low_first.pop_back());
  endtask

  // compare digit transfers, then predict new values, then track the radix
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_digits.delete();
      radix_q = RADIX_MIN;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $error("digit transfer %0d (last_digit %0b) with no digit pending",
                 out_digit, out_last_digit);
          mismatch_count++;
        end else begin
          oldest = expected_digits.pop_front();
          if (out_digit !== oldest.digit) begin
            $error("digit: expected %0d, actual %0d", oldest.digit, out_digit);
            mismatch_count++;
          end
          if (out_last_digit !== oldest.last_digit) begin
            $error("last_digit: expected %0b, actual %0b",
                   oldest.last_digit, out_last_digit);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) queue_digits(in_value, radix_q);
      if (cfg_wr_en) radix_q = clamp_radix(cfg_wr_data);
    end
    pending_digits = expected_digits.size();
  end

endmodule

FILE: bench/radix_digit_converter_test.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_test - regression for the radix digit converter
// Writes radix settings in and out of range between phases, sends directed
// boundary values and then random values under changing idle patterns on
// both channels, including a long receiver hold-off; the checker beside the
// block predicts and compares every digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter_test;
  import rdc_pkg::*;

  localparam int          VW            = VALUE_WIDTH_DEF;
  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 12;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PRESS_ITEMS   = 8;
  localparam int          RANDOM_PHASES = 12;
  localparam int          PHASE_ITEMS   = 27;
  localparam int          TAIL_CYCLES   = 200;
  localparam int          RUN_LIMIT_NS  = 100_000_000;
  localparam logic [63:0] VALUE_MAX     = (64'd1 << VW) - 1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_wr_en      = 1'b0;
  logic [RADIX_W-1:0] cfg_wr_data    = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [VW-1:0]      in_value       = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [DIGIT_W-1:0] out_digit;
  logic               out_last_digit;
  logic               hold_start     = 1'b0;

  int pending_digits;
  int mismatch_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  always #(CLK_HALF) clk = ~clk;

  radix_digit_converter #(.VALUE_WIDTH(VW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit)
  );

  radix_digit_converter_check #(.VALUE_WIDTH(VW)) check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit),
    .pending_digits (pending_digits),
    .mismatch_count (mismatch_count)
  );

  // receiver: random stalls, or a long hold-off counted here once requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // idle pattern for the next stretch of transfers
  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default:   begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // offer one value and hold it until the transfer
  task automatic send_value(input logic [VW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending until every predicted digit has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_digits != 0);
  endtask

  // radix write, only once the block has gone idle
  task automatic set_radix(input logic [RADIX_W-1:0] wr);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= wr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random value: full width, random length, small, or near a power of a radix
  function automatic logic [VW-1:0] pick_value();
    logic [63:0] p;
    int          base;
    case ($urandom_range(3))
      0: return VW'($urandom);
      1: return VW'($urandom) >> $urandom_range(VW - 1);
      2: return VW'($urandom_range(99));
      default: begin
        base = $urandom_range(9, 2);
        p    = 1;
        repeat ($urandom_range(31)) if (p * base <= VALUE_MAX) p = p * base;
        return VW'(p - $urandom_range(1));
      end
    endcase
  endfunction

  // stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clamped and exact radix writes, zero, full scale, bit patterns
    set_idle(IDLE_NONE);
    set_radix(4'd0);
    send_value('0);
    send_value(VW'(1));
    send_value(VW'(VALUE_MAX));
    send_value(VW'(64'h5555_5555));
    send_value(VW'(64'h2AAA_AAAA));
    set_radix(4'd15);
    send_value('0);
    send_value(VW'(8));
    send_value(VW'(9));
    send_value(VW'(80));
    send_value(VW'(81));
    send_value(VW'(VALUE_MAX));
    set_radix(4'd1);
    send_value(VW'(2));
    send_value(VW'(3));
    set_radix(4'd10);
    send_value(VW'(728));
    send_value(VW'(729));
    set_radix(4'd3);
    send_value(VW'(26));
    send_value(VW'(27));
    set_radix(4'd2);
    send_value(VW'(4));
    set_radix(4'd9);
    send_value(VW'(6560));

    // random phases, each with its own radix and idle pattern
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_radix(RADIX_W'($urandom_range(15)));
      set_idle(idle_mode_t'(ph % 4));
      repeat (PHASE_ITEMS) send_value(pick_value());

      // long receiver hold-off while the sender keeps offering values
      if (ph == RANDOM_PHASES / 2) begin
        set_idle(IDLE_NONE);
        in_valid   <= 1'b0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (PRESS_ITEMS) send_value(pick_value());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
sv/rdc_pkg.sv
sv/rdc_front.sv
sv/rdc_queue.sv
sv/rdc_back.sv
sv/radix_digit_converter.sv
bench/radix_digit_converter_check.sv
bench/radix_digit_converter_test.sv
